// File: hdl/assert_macros.svh
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also watches the cycles in reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/hbpc_pkg.sv
// Package with the constants, codes and types of the ball and post centroid block.
`default_nettype none

package hbpc_pkg;

    // Frame geometry and gap rule.
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int GAP_COLUMNS = 20;

    // Field and state widths.
    localparam int PIX_W       = 8;
    localparam int COORD_W     = 10;
    localparam int CFG_IDX_W   = 4;
    localparam int SUM_W       = 32;
    localparam int CNT_W       = 21;
    localparam int GAP_W       = 6;
    localparam int NUM_ACC     = 3;
    localparam int ACC_W       = $clog2(NUM_ACC);
    localparam int NUM_MEAN    = 2 * NUM_ACC;
    localparam int MEAN_IDX_W  = $clog2(NUM_MEAN);
    localparam int QUEUE_DEPTH = 4;

    // Accumulator slots.
    localparam logic [ACC_W-1:0] ACC_BALL  = ACC_W'(0);
    localparam logic [ACC_W-1:0] ACC_POST0 = ACC_W'(1);
    localparam logic [ACC_W-1:0] ACC_POST1 = ACC_W'(2);

    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [GAP_W-1:0] GAP_MAX   = '1;
    localparam logic [GAP_W-1:0] GAP_LIMIT = GAP_W'(GAP_COLUMNS);

    // Register reset values.
    localparam logic [PIX_W-1:0] RST_BALL_HUE_LOW  = 8'd19;
    localparam logic [PIX_W-1:0] RST_BALL_HUE_HIGH = 8'd24;
    localparam logic [PIX_W-1:0] RST_BALL_SAT_LOW  = 8'd239;
    localparam logic [PIX_W-1:0] RST_BALL_SAT_HIGH = 8'd250;
    localparam logic [PIX_W-1:0] RST_BALL_VAL_LOW  = 8'd221;
    localparam logic [PIX_W-1:0] RST_POST_SAT_LOW  = 8'd171;
    localparam logic [PIX_W-1:0] RST_POST_SAT_HIGH = 8'd220;
    localparam logic [PIX_W-1:0] RST_POST_VAL_LOW  = 8'd216;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BALL_HUE_LOW  = 4'd0,
        CFG_BALL_HUE_HIGH = 4'd1,
        CFG_BALL_SAT_LOW  = 4'd2,
        CFG_BALL_SAT_HIGH = 4'd3,
        CFG_BALL_VAL_LOW  = 4'd4,
        CFG_POST_SAT_LOW  = 4'd5,
        CFG_POST_SAT_HIGH = 4'd6,
        CFG_POST_VAL_LOW  = 4'd7
    } t_cfg_index;

    // One classified pixel word as it sits in the queue.
    typedef struct packed {
        logic               ball;
        logic               post;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               col_end;
        logic               frame_end;
    } t_word;

    // Queue fill status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// File: hdl/hbpc_front.sv
// Front end: configuration registers and color window classification of pixels.
`default_nettype none

module hbpc_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [hbpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hbpc_pkg::PIX_W-1:0]  i_cfg_data,
    input  wire logic [hbpc_pkg::PIX_W-1:0]  i_hue,
    input  wire logic [hbpc_pkg::PIX_W-1:0]  i_saturation,
    input  wire logic [hbpc_pkg::PIX_W-1:0]  i_brightness,
    input  wire logic [hbpc_pkg::COORD_W-1:0] i_column,
    input  wire logic [hbpc_pkg::COORD_W-1:0] i_row,
    input  wire logic                        i_column_end,
    input  wire logic                        i_frame_end,
    output hbpc_pkg::t_word                  o_word
);
    import hbpc_pkg::*;

    logic [PIX_W-1:0] r_ball_hue_low, r_ball_hue_high, r_ball_sat_low, r_ball_sat_high;
    logic [PIX_W-1:0] r_ball_val_low, r_post_sat_low, r_post_sat_high, r_post_val_low;
    logic             in_range;

    // The register port never stalls.
    assign o_cfg_ready = 1'b1;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ball_hue_low  <= RST_BALL_HUE_LOW;
            r_ball_hue_high <= RST_BALL_HUE_HIGH;
            r_ball_sat_low  <= RST_BALL_SAT_LOW;
            r_ball_sat_high <= RST_BALL_SAT_HIGH;
            r_ball_val_low  <= RST_BALL_VAL_LOW;
            r_post_sat_low  <= RST_POST_SAT_LOW;
            r_post_sat_high <= RST_POST_SAT_HIGH;
            r_post_val_low  <= RST_POST_VAL_LOW;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BALL_HUE_LOW:  r_ball_hue_low  <= i_cfg_data;
                CFG_BALL_HUE_HIGH: r_ball_hue_high <= i_cfg_data;
                CFG_BALL_SAT_LOW:  r_ball_sat_low  <= i_cfg_data;
                CFG_BALL_SAT_HIGH: r_ball_sat_high <= i_cfg_data;
                CFG_BALL_VAL_LOW:  r_ball_val_low  <= i_cfg_data;
                CFG_POST_SAT_LOW:  r_post_sat_low  <= i_cfg_data;
                CFG_POST_SAT_HIGH: r_post_sat_high <= i_cfg_data;
                CFG_POST_VAL_LOW:  r_post_val_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pixels outside the frame match no color.
    assign in_range = (32'(i_column) < MAX_WIDTH) && (32'(i_row) < MAX_HEIGHT);

    // Inclusive window tests; an inverted window matches nothing.
    always_comb begin
        o_word.ball = in_range
            && (i_hue >= r_ball_hue_low) && (i_hue <= r_ball_hue_high)
            && (i_saturation >= r_ball_sat_low) && (i_saturation <= r_ball_sat_high)
            && (i_brightness >= r_ball_val_low);
        o_word.post = in_range
            && (i_saturation >= r_post_sat_low) && (i_saturation <= r_post_sat_high)
            && (i_brightness >= r_post_val_low);
        o_word.column    = i_column;
        o_word.row       = i_row;
        o_word.col_end   = i_column_end;
        o_word.frame_end = i_frame_end;
    end

endmodule

`default_nettype wire

// File: hdl/hbpc_queue.sv
// Short queue of classified pixel words between the front and the back end.
`default_nettype none

module hbpc_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  hbpc_pkg::t_word  i_word,
    input  wire logic        i_pop,
    output hbpc_pkg::t_word  o_word,
    output hbpc_pkg::t_q_status o_status
);
    import hbpc_pkg::*;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(QUEUE_DEPTH);

    t_word              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [COUNT_W-1:0] r_count;
    logic               do_push, do_pop;

    assign o_status.full  = (r_count == COUNT_FULL);
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_word  = r_mem[r_rd_ptr];

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/hbpc_back.sv
// Back end: coordinate accumulation, post gap tracking, frame-end division and result register.
`default_nettype none

module hbpc_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  hbpc_pkg::t_word  i_word,
    input  hbpc_pkg::t_q_status i_status,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_ball_found,
    output logic [hbpc_pkg::COORD_W-1:0] o_ball_x,
    output logic [hbpc_pkg::COORD_W-1:0] o_ball_y,
    output logic             o_first_post_found,
    output logic [hbpc_pkg::COORD_W-1:0] o_first_post_x,
    output logic [hbpc_pkg::COORD_W-1:0] o_first_post_y,
    output logic             o_second_post_found,
    output logic [hbpc_pkg::COORD_W-1:0] o_second_post_x,
    output logic [hbpc_pkg::COORD_W-1:0] o_second_post_y
);
    import hbpc_pkg::*;

    // The bit counter runs from COORD_W (load) down to zero.
    localparam int BIT_W = $clog2(COORD_W + 1);
    localparam logic [BIT_W-1:0]      BIT_LOAD  = BIT_W'(COORD_W);
    localparam logic [MEAN_IDX_W-1:0] MEAN_LAST = MEAN_IDX_W'(NUM_MEAN - 1);

    typedef enum logic [1:0] {
        S_ACC,
        S_DIV,
        S_HOLD
    } t_state;

    t_state             r_state;
    logic [SUM_W-1:0]   r_sum_x [NUM_ACC];
    logic [SUM_W-1:0]   r_sum_y [NUM_ACC];
    logic [CNT_W-1:0]   r_cnt   [NUM_ACC];
    logic [SUM_W-1:0]   n_sum_x [NUM_ACC];
    logic [SUM_W-1:0]   n_sum_y [NUM_ACC];
    logic [CNT_W-1:0]   n_cnt   [NUM_ACC];
    logic               r_select, n_select;
    logic [GAP_W-1:0]   r_gap, n_gap;
    logic               r_saw, n_saw;

    logic [MEAN_IDX_W-1:0] r_div_idx;
    logic [BIT_W-1:0]      r_bit;
    logic [SUM_W-1:0]      r_rem;
    logic [COORD_W-1:0]    r_quot;
    logic [COORD_W-1:0]    r_mean [NUM_MEAN];

    logic [ACC_W-1:0]   post_k;
    logic               post0_nz;
    logic [ACC_W-1:0]   div_acc;
    logic [SUM_W-1:0]   div_sum, div_den;
    logic               div_ge;
    logic [COORD_W-1:0] quot_next;
    logic               out_free;

    assign o_pop    = (r_state == S_ACC) && !i_status.empty;
    assign out_free = !o_valid || !i_stall;
    assign post_k   = r_select ? ACC_POST1 : ACC_POST0;

    // Next accumulator and gap state for the word at the head of the queue.
    always_comb begin
        for (int a = 0; a < NUM_ACC; a++) begin
            n_sum_x[a] = r_sum_x[a];
            n_sum_y[a] = r_sum_y[a];
            n_cnt[a]   = r_cnt[a];
        end
        n_select = r_select;
        n_gap    = r_gap;
        n_saw    = r_saw;
        post0_nz = (r_cnt[ACC_POST0] != '0) || (i_word.post && !r_select);

        if (i_word.ball && (r_cnt[ACC_BALL] != CNT_MAX)) begin
            n_sum_x[ACC_BALL] = r_sum_x[ACC_BALL] + SUM_W'(i_word.column);
            n_sum_y[ACC_BALL] = r_sum_y[ACC_BALL] + SUM_W'(i_word.row);
            n_cnt[ACC_BALL]   = r_cnt[ACC_BALL] + 1'b1;
        end
        if (i_word.post) begin
            n_saw = 1'b1;
            if (r_cnt[post_k] != CNT_MAX) begin
                n_sum_x[post_k] = r_sum_x[post_k] + SUM_W'(i_word.column);
                n_sum_y[post_k] = r_sum_y[post_k] + SUM_W'(i_word.row);
                n_cnt[post_k]   = r_cnt[post_k] + 1'b1;
            end
        end

        // A post-free column after the first post pixel extends the gap.
        if (i_word.col_end) begin
            if (post0_nz && !n_saw && (r_gap != GAP_MAX)) begin
                n_gap = r_gap + 1'b1;
            end
            if (n_gap > GAP_LIMIT) begin
                n_select = 1'b1;
            end
            n_saw = 1'b0;
        end
    end

    // One restoring step a cycle; the mean fits in COORD_W bits since each
    // coordinate is below 2^COORD_W, so only that many quotient bits are formed.
    assign div_acc   = ACC_W'(r_div_idx >> 1);
    assign div_sum   = r_div_idx[0] ? r_sum_y[div_acc] : r_sum_x[div_acc];
    assign div_den   = SUM_W'(r_cnt[div_acc]) << r_bit;
    assign div_ge    = (r_rem >= div_den);
    always_comb begin
        quot_next = r_quot;
        if (div_ge) begin
            quot_next[r_bit[$clog2(COORD_W)-1:0]] = 1'b1;
        end
    end

    // State, accumulators, divider and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_ACC;
            o_valid  <= 1'b0;
            r_select <= 1'b0;
            r_gap    <= '0;
            r_saw    <= 1'b0;
            for (int a = 0; a < NUM_ACC; a++) begin
                r_sum_x[a] <= '0;
                r_sum_y[a] <= '0;
                r_cnt[a]   <= '0;
            end
        end else begin
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_ACC: begin
                    if (!i_status.empty) begin
                        for (int a = 0; a < NUM_ACC; a++) begin
                            r_sum_x[a] <= n_sum_x[a];
                            r_sum_y[a] <= n_sum_y[a];
                            r_cnt[a]   <= n_cnt[a];
                        end
                        r_select <= n_select;
                        r_gap    <= n_gap;
                        r_saw    <= n_saw;
                        if (i_word.frame_end) begin
                            r_state   <= S_DIV;
                            r_div_idx <= '0;
                            r_bit     <= BIT_LOAD;
                        end
                    end
                end
                S_DIV: begin
                    if (r_bit == BIT_LOAD) begin
                        r_rem  <= div_sum;
                        r_quot <= '0;
                        r_bit  <= r_bit - 1'b1;
                    end else begin
                        if (div_ge) begin
                            r_rem <= r_rem - div_den;
                        end
                        r_quot <= quot_next;
                        if (r_bit == '0) begin
                            r_mean[r_div_idx] <= quot_next;
                            r_bit <= BIT_LOAD;
                            if (r_div_idx == MEAN_LAST) begin
                                r_state <= S_HOLD;
                            end else begin
                                r_div_idx <= r_div_idx + 1'b1;
                            end
                        end else begin
                            r_bit <= r_bit - 1'b1;
                        end
                    end
                end
                S_HOLD: begin
                    // Publish once the result register is free, then start a new frame.
                    if (out_free) begin
                        o_valid             <= 1'b1;
                        o_ball_found        <= (r_cnt[ACC_BALL] != '0);
                        o_ball_x            <= (r_cnt[ACC_BALL] != '0) ? r_mean[0] : '0;
                        o_ball_y            <= (r_cnt[ACC_BALL] != '0) ? r_mean[1] : '0;
                        o_first_post_found  <= (r_cnt[ACC_POST0] != '0);
                        o_first_post_x      <= (r_cnt[ACC_POST0] != '0) ? r_mean[2] : '0;
                        o_first_post_y      <= (r_cnt[ACC_POST0] != '0) ? r_mean[3] : '0;
                        o_second_post_found <= (r_cnt[ACC_POST1] != '0);
                        o_second_post_x     <= (r_cnt[ACC_POST1] != '0) ? r_mean[4] : '0;
                        o_second_post_y     <= (r_cnt[ACC_POST1] != '0) ? r_mean[5] : '0;
                        for (int a = 0; a < NUM_ACC; a++) begin
                            r_sum_x[a] <= '0;
                            r_sum_y[a] <= '0;
                            r_cnt[a]   <= '0;
                        end
                        r_select <= 1'b0;
                        r_gap    <= '0;
                        r_saw    <= 1'b0;
                        r_state  <= S_ACC;
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/hsv_ball_post_centroid.sv
// Top level of the HSV ball and post centroid block.
//
// Pixels of one frame enter on the input channel (i_valid / o_stall) in
// column-major order with their column, row and end marks. Each pixel is
// classified against the ball and post color windows as it is accepted and
// lands in a four-word queue; the back end takes one word a cycle from it
// while it is accumulating a frame. The eight window registers are written
// through the register port, which is always ready; write them only while
// the block is idle. Throughput is one pixel per cycle while the queue has
// room. After a frame_end word the back end runs one shared restoring
// divider for six means in turn, and the result word appears on o_valid /
// i_stall after all six. Meanwhile the queue fills with the following
// pixels, and o_stall then stays high until the result is registered.
// A result waits in its output register while i_stall is high; the next
// frame accumulates meanwhile, and only its own result must wait for the
// register to free up. Synchronous reset restores the window defaults,
// empties the queue, clears the frame accumulators and drops o_valid.
`default_nettype none

module hsv_ball_post_centroid (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [hbpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hbpc_pkg::PIX_W-1:0]     i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [hbpc_pkg::PIX_W-1:0]     i_hue,
    input  wire logic [hbpc_pkg::PIX_W-1:0]     i_saturation,
    input  wire logic [hbpc_pkg::PIX_W-1:0]     i_brightness,
    input  wire logic [hbpc_pkg::COORD_W-1:0]   i_column,
    input  wire logic [hbpc_pkg::COORD_W-1:0]   i_row,
    input  wire logic        i_column_end,
    input  wire logic        i_frame_end,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_ball_found,
    output logic [hbpc_pkg::COORD_W-1:0] o_ball_x,
    output logic [hbpc_pkg::COORD_W-1:0] o_ball_y,
    output logic             o_first_post_found,
    output logic [hbpc_pkg::COORD_W-1:0] o_first_post_x,
    output logic [hbpc_pkg::COORD_W-1:0] o_first_post_y,
    output logic             o_second_post_found,
    output logic [hbpc_pkg::COORD_W-1:0] o_second_post_x,
    output logic [hbpc_pkg::COORD_W-1:0] o_second_post_y
);
    import hbpc_pkg::*;

    t_word     front_word, head_word;
    t_q_status q_status;
    logic      pop;

    // The input stalls only while the queue is full.
    assign o_stall = q_status.full;

    hbpc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .i_column     (i_column),
        .i_row        (i_row),
        .i_column_end (i_column_end),
        .i_frame_end  (i_frame_end),
        .o_word       (front_word)
    );

    hbpc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_valid),
        .i_word   (front_word),
        .i_pop    (pop),
        .o_word   (head_word),
        .o_status (q_status)
    );

    hbpc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_word              (head_word),
        .i_status            (q_status),
        .o_pop               (pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_ball_found        (o_ball_found),
        .o_ball_x            (o_ball_x),
        .o_ball_y            (o_ball_y),
        .o_first_post_found  (o_first_post_found),
        .o_first_post_x      (o_first_post_x),
        .o_first_post_y      (o_first_post_y),
        .o_second_post_found (o_second_post_found),
        .o_second_post_x     (o_second_post_x),
        .o_second_post_y     (o_second_post_y)
    );

endmodule

`default_nettype wire

// File: hdl/hbpc_checker.sv
// Port-level checker for the ball and post centroid block, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module hbpc_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        o_cfg_ready,
    input  wire logic [hbpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hbpc_pkg::PIX_W-1:0]     i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic        o_stall,
    input  wire logic [hbpc_pkg::PIX_W-1:0]     i_hue,
    input  wire logic [hbpc_pkg::PIX_W-1:0]     i_saturation,
    input  wire logic [hbpc_pkg::PIX_W-1:0]     i_brightness,
    input  wire logic [hbpc_pkg::COORD_W-1:0]   i_column,
    input  wire logic [hbpc_pkg::COORD_W-1:0]   i_row,
    input  wire logic        i_column_end,
    input  wire logic        i_frame_end,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire logic        o_ball_found,
    input  wire logic [hbpc_pkg::COORD_W-1:0] o_ball_x,
    input  wire logic [hbpc_pkg::COORD_W-1:0] o_ball_y,
    input  wire logic        o_first_post_found,
    input  wire logic [hbpc_pkg::COORD_W-1:0] o_first_post_x,
    input  wire logic [hbpc_pkg::COORD_W-1:0] o_first_post_y,
    input  wire logic        o_second_post_found,
    input  wire logic [hbpc_pkg::COORD_W-1:0] o_second_post_x,
    input  wire logic [hbpc_pkg::COORD_W-1:0] o_second_post_y
);

    // A stalled result word holds.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_ball_x) && $stable(o_first_post_y) && $stable(o_second_post_found), "result word changed while stalled")

    // An empty ball accumulator reports zero coordinates.
    `ASSERT_CLK(a_ball_empty, i_clk, i_rst_n, o_valid && !o_ball_found |-> o_ball_x == '0 && o_ball_y == '0, "ball coordinates not zero without ball pixels")

    // The second post can only fill after the first one has pixels.
    `ASSERT_CLK(a_post_order, i_clk, i_rst_n, o_valid && o_second_post_found |-> o_first_post_found, "second post found without a first post")

    // Reset empties the result register.
    `ASSERT_CLK_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_valid, "result valid right after reset")

endmodule

bind hsv_ball_post_centroid hbpc_checker u_checker (.*);

`default_nettype wire

// File: bench/hbpc_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the ball and post centroid block: tracks every frame and compares its result.
module hbpc_result_checker
    import hbpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data,
    input  logic                 i_pix_valid,
    input  logic                 i_pix_stall,
    input  logic [PIX_W-1:0]     i_hue,
    input  logic [PIX_W-1:0]     i_saturation,
    input  logic [PIX_W-1:0]     i_brightness,
    input  logic [COORD_W-1:0]   i_column,
    input  logic [COORD_W-1:0]   i_row,
    input  logic                 i_column_end,
    input  logic                 i_frame_end,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic                 i_ball_found,
    input  logic [COORD_W-1:0]   i_ball_x,
    input  logic [COORD_W-1:0]   i_ball_y,
    input  logic                 i_first_post_found,
    input  logic [COORD_W-1:0]   i_first_post_x,
    input  logic [COORD_W-1:0]   i_first_post_y,
    input  logic                 i_second_post_found,
    input  logic [COORD_W-1:0]   i_second_post_x,
    input  logic [COORD_W-1:0]   i_second_post_y,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_frame_count,
    output int                   o_second_post_count
);

    // One frame result word: presence flag and mean position per accumulator.
    typedef struct packed {
        logic               ball_found;
        logic [COORD_W-1:0] ball_x;
        logic [COORD_W-1:0] ball_y;
        logic               first_found;
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic               second_found;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
    } t_centroids;

    // Copy of the color window registers.
    logic [PIX_W-1:0] ball_hue_low, ball_hue_high, ball_sat_low, ball_sat_high;
    logic [PIX_W-1:0] ball_val_low, post_sat_low, post_sat_high, post_val_low;

    // Frame accumulators; index 0 is the first post, index 1 the second.
    logic [SUM_W-1:0] ball_sum_x, ball_sum_y;
    logic [CNT_W-1:0] ball_count;
    logic [SUM_W-1:0] post_sum_x [2];
    logic [SUM_W-1:0] post_sum_y [2];
    logic [CNT_W-1:0] post_count [2];
    logic             post_select;
    logic [GAP_W-1:0] gap_count;
    logic             column_saw_post;

    t_centroids centroid_q[$];
    int fail_count;
    int frame_count;
    int second_post_count;
    int pending;

    assign o_fail_count        = fail_count;
    assign o_pending           = pending;
    assign o_frame_count       = frame_count;
    assign o_second_post_count = second_post_count;

    function automatic logic [COORD_W-1:0] mean_of(input logic [SUM_W-1:0] sum,
                                                   input logic [CNT_W-1:0] count);
        logic [SUM_W-1:0] quotient;
        quotient = (count == 0) ? '0 : sum / count;
        return quotient[COORD_W-1:0];
    endfunction

    task automatic clear_frame();
        ball_sum_x      = '0;
        ball_sum_y      = '0;
        ball_count      = '0;
        for (int k = 0; k < 2; k++) begin
            post_sum_x[k] = '0;
            post_sum_y[k] = '0;
            post_count[k] = '0;
        end
        post_select     = 1'b0;
        gap_count       = '0;
        column_saw_post = 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Register write seen on the configuration port.
    task automatic apply_register();
        case (t_cfg_index'(i_cfg_index))
            CFG_BALL_HUE_LOW:  ball_hue_low  = i_cfg_data;
            CFG_BALL_HUE_HIGH: ball_hue_high = i_cfg_data;
            CFG_BALL_SAT_LOW:  ball_sat_low  = i_cfg_data;
            CFG_BALL_SAT_HIGH: ball_sat_high = i_cfg_data;
            CFG_BALL_VAL_LOW:  ball_val_low  = i_cfg_data;
            CFG_POST_SAT_LOW:  post_sat_low  = i_cfg_data;
            CFG_POST_SAT_HIGH: post_sat_high = i_cfg_data;
            CFG_POST_VAL_LOW:  post_val_low  = i_cfg_data;
            default: ;
        endcase
    endtask

    // Classify one accepted pixel, update the sums, and close the frame on its end mark.
    task automatic track_pixel();
        logic       in_frame;
        logic       is_ball;
        logic       is_post;
        logic       k;
        t_centroids res;
        in_frame = (int'(i_column) < MAX_WIDTH) && (int'(i_row) < MAX_HEIGHT);
        is_ball  = in_frame
                   && i_hue >= ball_hue_low && i_hue <= ball_hue_high
                   && i_saturation >= ball_sat_low && i_saturation <= ball_sat_high
                   && i_brightness >= ball_val_low;
        is_post  = in_frame
                   && i_saturation >= post_sat_low && i_saturation <= post_sat_high
                   && i_brightness >= post_val_low;

        // A full accumulator ignores further pixels.
        if (is_ball && ball_count != CNT_MAX) begin
            ball_sum_x = ball_sum_x + i_column;
            ball_sum_y = ball_sum_y + i_row;
            ball_count = ball_count + 1'b1;
        end
        if (is_post) begin
            k = post_select;
            column_saw_post = 1'b1;
            if (post_count[k] != CNT_MAX) begin
                post_sum_x[k] = post_sum_x[k] + i_column;
                post_sum_y[k] = post_sum_y[k] + i_row;
                post_count[k] = post_count[k] + 1'b1;
            end
        end

        // Count post-free columns once the first post has started; the counter saturates.
        if (i_column_end) begin
            if (post_count[0] != 0 && !column_saw_post && gap_count != GAP_MAX)
                gap_count = gap_count + 1'b1;
            if (int'(gap_count) > GAP_COLUMNS)
                post_select = 1'b1;
            column_saw_post = 1'b0;
        end

        if (i_frame_end) begin
            res.ball_found   = (ball_count != 0);
            res.ball_x       = mean_of(ball_sum_x, ball_count);
            res.ball_y       = mean_of(ball_sum_y, ball_count);
            res.first_found  = (post_count[0] != 0);
            res.first_x      = mean_of(post_sum_x[0], post_count[0]);
            res.first_y      = mean_of(post_sum_y[0], post_count[0]);
            res.second_found = (post_count[1] != 0);
            res.second_x     = mean_of(post_sum_x[1], post_count[1]);
            res.second_y     = mean_of(post_sum_y[1], post_count[1]);
            centroid_q.push_back(res);
            clear_frame();
        end
    endtask

    // Compare one accepted result word with the oldest frame waiting.
    task automatic compare_result();
        t_centroids want;
        if (centroid_q.size() == 0) begin
            fail_count++;
            $error("result word with no frame waiting for it");
        end else begin
            want = centroid_q.pop_front();
            check_field("ball_found", want.ball_found, i_ball_found);
            check_field("ball_x", want.ball_x, i_ball_x);
            check_field("ball_y", want.ball_y, i_ball_y);
            check_field("first_post_found", want.first_found, i_first_post_found);
            check_field("first_post_x", want.first_x, i_first_post_x);
            check_field("first_post_y", want.first_y, i_first_post_y);
            check_field("second_post_found", want.second_found, i_second_post_found);
            check_field("second_post_x", want.second_x, i_second_post_x);
            check_field("second_post_y", want.second_y, i_second_post_y);
            frame_count++;
            if (want.second_found)
                second_post_count++;
        end
    endtask

    initial begin
        fail_count        = 0;
        frame_count       = 0;
        second_post_count = 0;
        pending           = 0;
    end

    // All handshakes are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ball_hue_low  = RST_BALL_HUE_LOW;
            ball_hue_high = RST_BALL_HUE_HIGH;
            ball_sat_low  = RST_BALL_SAT_LOW;
            ball_sat_high = RST_BALL_SAT_HIGH;
            ball_val_low  = RST_BALL_VAL_LOW;
            post_sat_low  = RST_POST_SAT_LOW;
            post_sat_high = RST_POST_SAT_HIGH;
            post_val_low  = RST_POST_VAL_LOW;
            clear_frame();
            centroid_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                apply_register();
            if (i_res_valid && !i_res_stall)
                compare_result();
            if (i_pix_valid && !i_pix_stall)
                track_pixel();
        end
        pending = centroid_q.size();
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the ball and post centroid block: clock, reset, stimulus and verdict.
module tb_top;
    import hbpc_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 80;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_PIXELS = 105;
    localparam int MAX_COORD    = (1 << COORD_W) - 1;

    typedef struct packed {
        logic [PIX_W-1:0] ball_hue_low;
        logic [PIX_W-1:0] ball_hue_high;
        logic [PIX_W-1:0] ball_sat_low;
        logic [PIX_W-1:0] ball_sat_high;
        logic [PIX_W-1:0] ball_val_low;
        logic [PIX_W-1:0] post_sat_low;
        logic [PIX_W-1:0] post_sat_high;
        logic [PIX_W-1:0] post_val_low;
    } t_windows;

    typedef struct packed {
        logic [PIX_W-1:0]   hue;
        logic [PIX_W-1:0]   saturation;
        logic [PIX_W-1:0]   brightness;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               column_end;
        logic               frame_end;
    } t_pixel;

    typedef enum int { PIX_BALL, PIX_POST, PIX_DARK, PIX_NOISE } t_pix_class;
    typedef enum int { FRAME_PLAIN, FRAME_GAP, FRAME_BROKEN } t_frame_kind;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PIX_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    t_pixel               pix_word;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_ball_found;
    logic [COORD_W-1:0]   o_ball_x, o_ball_y;
    logic                 o_first_post_found;
    logic [COORD_W-1:0]   o_first_post_x, o_first_post_y;
    logic                 o_second_post_found;
    logic [COORD_W-1:0]   o_second_post_x, o_second_post_y;

    int       fail_count, pending, frame_count, second_post_count;
    int       pixels_sent;
    int       quiet_cycles;
    int       send_idle_pct;
    int       recv_idle_pct;
    logic     hold_request;
    t_windows win;

    hsv_ball_post_centroid dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_hue               (pix_word.hue),
        .i_saturation        (pix_word.saturation),
        .i_brightness        (pix_word.brightness),
        .i_column            (pix_word.column),
        .i_row               (pix_word.row),
        .i_column_end        (pix_word.column_end),
        .i_frame_end         (pix_word.frame_end),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_ball_found        (o_ball_found),
        .o_ball_x            (o_ball_x),
        .o_ball_y            (o_ball_y),
        .o_first_post_found  (o_first_post_found),
        .o_first_post_x      (o_first_post_x),
        .o_first_post_y      (o_first_post_y),
        .o_second_post_found (o_second_post_found),
        .o_second_post_x     (o_second_post_x),
        .o_second_post_y     (o_second_post_y)
    );

    hbpc_result_checker u_result_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_pix_valid         (i_valid),
        .i_pix_stall         (o_stall),
        .i_hue               (pix_word.hue),
        .i_saturation        (pix_word.saturation),
        .i_brightness        (pix_word.brightness),
        .i_column            (pix_word.column),
        .i_row               (pix_word.row),
        .i_column_end        (pix_word.column_end),
        .i_frame_end         (pix_word.frame_end),
        .i_res_valid         (o_valid),
        .i_res_stall         (i_stall),
        .i_ball_found        (o_ball_found),
        .i_ball_x            (o_ball_x),
        .i_ball_y            (o_ball_y),
        .i_first_post_found  (o_first_post_found),
        .i_first_post_x      (o_first_post_x),
        .i_first_post_y      (o_first_post_y),
        .i_second_post_found (o_second_post_found),
        .i_second_post_x     (o_second_post_x),
        .i_second_post_y     (o_second_post_y),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_frame_count       (frame_count),
        .o_second_post_count (second_post_count)
    );

    // Clock.
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // Watchdog: ends the run when no word moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, plus one long hold when asked for.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_stall = ($urandom_range(99, 0) < recv_idle_pct);
            end
        end
    end

    function automatic t_windows windows_of(input logic [PIX_W-1:0] hue_lo, hue_hi,
                                            sat_lo, sat_hi, val_lo,
                                            post_lo, post_hi, post_val);
        t_windows w;
        w.ball_hue_low  = hue_lo;
        w.ball_hue_high = hue_hi;
        w.ball_sat_low  = sat_lo;
        w.ball_sat_high = sat_hi;
        w.ball_val_low  = val_lo;
        w.post_sat_low  = post_lo;
        w.post_sat_high = post_hi;
        w.post_val_low  = post_val;
        return w;
    endfunction

    function automatic logic [PIX_W-1:0] pick_between(input logic [PIX_W-1:0] lo, hi);
        if (lo <= hi)
            return PIX_W'($urandom_range(hi, lo));
        return PIX_W'($urandom_range(255, 0));
    endfunction

    function automatic t_pixel make_fixed(input int hue, sat, val, col, row, col_end, frm_end);
        t_pixel p;
        p.hue        = hue;
        p.saturation = sat;
        p.brightness = val;
        p.column     = col;
        p.row        = row;
        p.column_end = col_end;
        p.frame_end  = frm_end;
        return p;
    endfunction

    // A pixel of the asked class under the windows now programmed; end marks are left low.
    function automatic t_pixel make_pixel(input t_pix_class cls, input int col, row);
        t_pixel           p;
        logic [PIX_W-1:0] dark_top;
        p = make_fixed($urandom_range(255, 0), $urandom_range(255, 0),
                       $urandom_range(255, 0), col, row, 0, 0);
        case (cls)
            PIX_BALL: begin
                p.hue        = pick_between(win.ball_hue_low, win.ball_hue_high);
                p.saturation = pick_between(win.ball_sat_low, win.ball_sat_high);
                p.brightness = pick_between(win.ball_val_low, 8'hFF);
            end
            PIX_POST: begin
                p.saturation = pick_between(win.post_sat_low, win.post_sat_high);
                p.brightness = pick_between(win.post_val_low, 8'hFF);
            end
            PIX_DARK: begin
                // Too dark for either color, where the windows leave room for that.
                dark_top = (win.ball_val_low < win.post_val_low) ? win.ball_val_low
                                                                 : win.post_val_low;
                if (dark_top != 0)
                    p.brightness = pick_between(8'd0, dark_top - 8'd1);
            end
            default: ;
        endcase
        return p;
    endfunction

    function automatic t_pix_class random_class();
        int r;
        r = $urandom_range(99, 0);
        if (r < 35)
            return PIX_BALL;
        if (r < 70)
            return PIX_POST;
        if (r < 88)
            return PIX_DARK;
        return PIX_NOISE;
    endfunction

    // Offer one pixel word and hold it until it is taken; called and returns at a falling edge.
    task automatic send_word(input t_pixel p);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid  = 1'b1;
        pix_word = p;
        do @(posedge i_clk); while (o_stall);
        pixels_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [PIX_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Wait until every frame result is out and the back end has surely gone quiet.
    task automatic wait_idle();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_windows(input t_windows w);
        wait_idle();
        write_reg(CFG_BALL_HUE_LOW, w.ball_hue_low);
        write_reg(CFG_BALL_HUE_HIGH, w.ball_hue_high);
        write_reg(CFG_BALL_SAT_LOW, w.ball_sat_low);
        write_reg(CFG_BALL_SAT_HIGH, w.ball_sat_high);
        write_reg(CFG_BALL_VAL_LOW, w.ball_val_low);
        write_reg(CFG_POST_SAT_LOW, w.post_sat_low);
        write_reg(CFG_POST_SAT_HIGH, w.post_sat_high);
        write_reg(CFG_POST_VAL_LOW, w.post_val_low);
        win = w;
    endtask

    // One frame in column-major order. Gap frames put a post in the first column, leave
    // a run of post-free columns, often long enough to switch posts, then add posts.
    task automatic send_frame(input t_frame_kind kind);
        int         width, height, gap_end, base_col, base_row;
        bit         post_column, open_end;
        t_pix_class cls;
        t_pixel     p;
        if (kind == FRAME_BROKEN) begin
            // Noise with random end marks; a frame may be left open for the next one.
            repeat ($urandom_range(5, 1)) begin
                p = make_pixel(PIX_NOISE, $urandom_range(MAX_COORD, 0),
                               $urandom_range(MAX_COORD, 0));
                p.column_end = $urandom_range(1, 0);
                p.frame_end  = ($urandom_range(3, 0) == 0);
                send_word(p);
            end
        end else begin
            if (kind == FRAME_GAP) begin
                height  = $urandom_range(2, 1);
                // Now and then a run long enough to saturate the gap counter.
                gap_end = ($urandom_range(5, 0) == 0) ? 66 : $urandom_range(24, 18);
                width   = gap_end + $urandom_range(8, 2);
            end else begin
                height  = $urandom_range(6, 1);
                width   = $urandom_range(8, 1);
                gap_end = 0;
            end
            base_col = $urandom_range(MAX_COORD + 1 - width, 0);
            base_row = $urandom_range(MAX_COORD + 1 - height, 0);
            open_end = ($urandom_range(7, 0) == 0);
            for (int c = 0; c < width; c++) begin
                post_column = (c == 0) || (c > gap_end && $urandom_range(9, 0) < 6);
                for (int r = 0; r < height; r++) begin
                    if (kind != FRAME_GAP)
                        cls = random_class();
                    else if (!post_column)
                        cls = PIX_DARK;
                    else if (r == 0)
                        cls = PIX_POST;
                    else
                        cls = random_class();
                    p = make_pixel(cls, base_col + c, base_row + r);
                    // The last column may end with the frame mark alone.
                    p.column_end = (r == height - 1) && !(open_end && c == width - 1);
                    p.frame_end  = (r == height - 1) && (c == width - 1);
                    send_word(p);
                end
            end
        end
    endtask

    task automatic run_random(input int count);
        int start, r;
        start = pixels_sent;
        while (pixels_sent - start < count) begin
            r = $urandom_range(99, 0);
            if (r < 55)
                send_frame(FRAME_PLAIN);
            else if (r < 85)
                send_frame(FRAME_GAP);
            else
                send_frame(FRAME_BROKEN);
        end
    endtask

    // Edge cases under the reset windows.
    task automatic run_directed();
        // Ball at the lower edges of its window, alone in a frame at the origin.
        send_word(make_fixed(19, 239, 221, 0, 0, 1, 1));
        // Ball at the upper edges, near misses on every bound but the upper ball saturation,
        // posts at the window edges, and a frame that ends without closing its column.
        send_word(make_fixed(24, 250, 255, MAX_COORD, MAX_COORD, 0, 0));
        send_word(make_fixed(25, 250, 255, 5, 5, 0, 0));
        send_word(make_fixed(18, 239, 221, 6, 6, 0, 0));
        send_word(make_fixed(20, 238, 255, 7, 7, 0, 0));
        send_word(make_fixed(20, 240, 220, 8, 8, 1, 0));
        send_word(make_fixed(0, 171, 216, 2, 1, 0, 0));
        send_word(make_fixed(255, 220, 255, 3, 700, 0, 0));
        send_word(make_fixed(0, 170, 255, 4, 9, 0, 0));
        send_word(make_fixed(0, 221, 255, 4, 10, 0, 0));
        send_word(make_fixed(0, 200, 215, 4, 11, 1, 0));
        send_word(make_fixed(0, 0, 0, 0, 0, 0, 1));
        // A frame with nothing in it.
        send_word(make_fixed(255, 255, 255, MAX_COORD, 0, 1, 1));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_BALL_HUE_LOW;
        i_cfg_data    = '0;
        pix_word      = '0;
        pixels_sent   = 0;
        quiet_cycles  = 0;
        hold_request  = 1'b0;
        send_idle_pct = 15;
        recv_idle_pct = 83;
        win = windows_of(RST_BALL_HUE_LOW, RST_BALL_HUE_HIGH, RST_BALL_SAT_LOW,
                         RST_BALL_SAT_HIGH, RST_BALL_VAL_LOW, RST_POST_SAT_LOW,
                         RST_POST_SAT_HIGH, RST_POST_VAL_LOW);
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset windows, sender mostly busy and receiver mostly stalled.
        run_directed();
        run_random(PHASE_PIXELS);

        // Windows wide open: every pixel is both ball and post.
        program_windows(windows_of(0, 255, 0, 255, 0, 0, 255, 0));
        run_random(PHASE_PIXELS);

        // Inverted windows match nothing; now the sender idles and the receiver rarely stalls.
        send_idle_pct = 83;
        recv_idle_pct = 15;
        program_windows(windows_of(255, 0, 200, 100, 255, 255, 0, 255));
        run_random(PHASE_PIXELS);

        // Random windows.
        begin
            logic [PIX_W-1:0] hue_lo, sat_lo, post_lo;
            hue_lo  = $urandom_range(200, 0);
            sat_lo  = $urandom_range(200, 0);
            post_lo = $urandom_range(200, 0);
            program_windows(windows_of(hue_lo, hue_lo + $urandom_range(55, 0),
                                       sat_lo, sat_lo + $urandom_range(55, 0),
                                       $urandom_range(255, 0),
                                       post_lo, post_lo + $urandom_range(55, 0),
                                       $urandom_range(255, 0)));
        end
        run_random(PHASE_PIXELS);

        // Reset windows written back, no idling, and one long hold on the result side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_windows(windows_of(RST_BALL_HUE_LOW, RST_BALL_HUE_HIGH, RST_BALL_SAT_LOW,
                                   RST_BALL_SAT_HIGH, RST_BALL_VAL_LOW, RST_POST_SAT_LOW,
                                   RST_POST_SAT_HIGH, RST_POST_VAL_LOW));
        hold_request = 1'b1;
        run_random(PHASE_PIXELS);

        wait_idle();
        $display("Covered %0d pixels under five window settings, three stall patterns",
                 pixels_sent);
        $display("and one long result hold; %0d frame results checked, %0d with a second post.",
                 frame_count, second_post_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/hbpc_pkg.sv
hdl/hbpc_front.sv
hdl/hbpc_queue.sv
hdl/hbpc_back.sv
hdl/hsv_ball_post_centroid.sv
hdl/hbpc_checker.sv
bench/hbpc_result_checker.sv
bench/tb_top.sv
